// ===== src/stbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package stbs_pkg;

	// operation codes of an input beat
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	// configuration register indexes (word addresses)
	localparam logic REG_ELEMENT_COUNT = 1'b0;

	localparam int unsigned COUNT_W = 5;
	localparam int unsigned INDEX_W = 4;
	localparam int unsigned VALUE_W = 32;

	typedef struct packed {
		logic                      opcode;
		logic [INDEX_W-1:0]        entry_index;
		logic signed [VALUE_W-1:0] data_value;
	} stbs_in_t;

	typedef struct packed {
		logic               found;
		logic [INDEX_W-1:0] position;
	} stbs_out_t;

	// controller to datapath
	typedef struct packed {
		logic wr_en;
		logic init;
		logic rd_en;
		logic step_left;
		logic step_right;
		logic emit_hit;
		logic emit_miss;
	} stbs_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic empty;
		logic eq;
		logic gt;
	} stbs_sts_t;

endpackage

`default_nettype wire

// ===== src/stbs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stbs_ctrl
	import stbs_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire logic      opcode,
	input  wire stbs_sts_t sts,
	output stbs_cmd_t      cmd,
	output logic           busy
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_PROBE,
		S_CMP
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   accept;

	assign accept = start && !busy_q;
	assign busy   = busy_q;

	always_comb begin
		cmd            = '0;
		cmd.wr_en      = accept && (opcode == OP_LOAD);
		cmd.init       = accept && (opcode == OP_SEARCH);
		case (state_q)
			S_PROBE: begin
				cmd.rd_en     = !sts.empty;
				cmd.emit_miss = sts.empty;
			end
			S_CMP: begin
				cmd.emit_hit   = sts.eq;
				cmd.step_left  = !sts.eq && sts.gt;
				cmd.step_right = !sts.eq && !sts.gt;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && (opcode == OP_SEARCH)) begin
						state_q <= S_PROBE;
						busy_q  <= 1'b1;
					end
				end
				S_PROBE: begin
					if (sts.empty) begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (sts.eq) begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end else begin
						state_q <= S_PROBE;
					end
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	a_search_enters_probe: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (opcode == OP_SEARCH)) |=> (state_q == S_PROBE))
		else $error("accepted search did not start probing");

	a_busy_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q == (state_q != S_IDLE))
		else $error("busy out of step with state");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_hit || cmd.emit_miss) |=> !(cmd.emit_hit || cmd.emit_miss))
		else $error("two results from one search");

endmodule

`default_nettype wire

// ===== src/stbs_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stbs_dpath
	import stbs_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = 16,
	parameter int unsigned ENTRY_WIDTH = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire stbs_in_t           item,
	input  wire logic [COUNT_W-1:0] element_count,
	input  wire stbs_cmd_t          cmd,
	output stbs_sts_t               sts,
	output stbs_out_t               result,
	output logic                    done
);

	localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
	localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

	logic [ENTRY_WIDTH-1:0]        mem [TABLE_DEPTH];
	logic signed [ENTRY_WIDTH-1:0] key_q;
	logic signed [ENTRY_WIDTH-1:0] rd_q;
	logic [CntW-1:0]               first_q;
	logic [CntW-1:0]               lim_q;
	logic [IdxW-1:0]               mid_q;
	logic                          done_q;
	stbs_out_t                     res_q;

	logic [CntW-1:0] cnt_eff;
	logic [CntW-1:0] span;
	logic [CntW-1:0] mid_w;
	logic            wr_ok;

	// counts above the table depth saturate
	assign cnt_eff = (32'(element_count) > TABLE_DEPTH) ? CntW'(TABLE_DEPTH)
	                                                    : CntW'(element_count);
	assign wr_ok   = 32'(item.entry_index) < TABLE_DEPTH;

	// mid = first + (last - first) / 2 with last = lim - 1
	assign span  = lim_q - CntW'(1) - first_q;
	assign mid_w = first_q + (span >> 1);

	assign sts.empty = !(first_q < lim_q);
	assign sts.eq    = (rd_q == key_q);
	assign sts.gt    = (rd_q > key_q);

	always_ff @(posedge clk) begin
		if (cmd.wr_en && wr_ok) begin
			mem[IdxW'(item.entry_index)] <= ENTRY_WIDTH'(item.data_value);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_q <= mem[mid_w[IdxW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			key_q   <= ENTRY_WIDTH'(item.data_value);
			first_q <= '0;
			lim_q   <= cnt_eff;
		end else if (cmd.step_left) begin
			lim_q   <= CntW'(mid_q);
		end else if (cmd.step_right) begin
			first_q <= CntW'(mid_q) + CntW'(1);
		end
		if (cmd.rd_en) begin
			mid_q <= mid_w[IdxW-1:0];
		end
		if (cmd.emit_hit) begin
			res_q.found    <= 1'b1;
			res_q.position <= INDEX_W'(mid_q);
		end else if (cmd.emit_miss) begin
			res_q.found    <= 1'b0;
			res_q.position <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit_hit || cmd.emit_miss;
		end
	end

	assign done   = done_q;
	assign result = res_q;

	a_miss_position_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.found) |-> (result.position == '0))
		else $error("miss reported a non-zero position");

	a_probe_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> ((mid_w < lim_q) && (mid_w >= first_q)))
		else $error("probe outside the search range");

	a_init_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.init |=> ((first_q == '0) && (lim_q <= CntW'(TABLE_DEPTH))))
		else $error("search range badly initialised");

endmodule

`default_nettype wire

// ===== src/sorted_table_binary_search.sv =====
// loads: a load beat is written at its accept edge and gives no result
// search: probe (table read) and compare states alternate after acceptance; a hit
//   is emitted in compare, a miss in an empty probe; at most 5 probes for 16 entries
// throughput: one beat per cycle for loads while not busy; a search holds busy
//   until its result, each probe a table read then a compare; receiver cannot stall
// reset: arst_n clears the controller, result strobe and element_count; table undefined
`timescale 1ns / 1ps
`default_nettype none

module sorted_table_binary_search
	import stbs_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = 16,
	parameter int unsigned ENTRY_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// command side
	input  wire logic        start,
	output logic             busy,
	input  wire stbs_in_t    item,
	// result side, one-cycle strobe
	output logic             done,
	output stbs_out_t        result,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [COUNT_W-1:0] count_q;
	logic               cfg_wr;
	stbs_cmd_t          cmd;
	stbs_sts_t          sts;

	// register write completes in the access phase; no wait states
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_wr && (paddr[2] == REG_ELEMENT_COUNT)) begin
			count_q <= pwdata[COUNT_W-1:0];
		end
	end

	// reads of unmapped words return zero
	assign prdata = (paddr[2] == REG_ELEMENT_COUNT) ? 32'(count_q) : '0;

	// sequencer: idle, probe (issue table read), compare (narrow the range)
	stbs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (item.opcode),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// table memory, search bounds, comparator and result register
	stbs_dpath #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.ENTRY_WIDTH (ENTRY_WIDTH)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (item),
		.element_count (count_q),
		.cmd           (cmd),
		.sts           (sts),
		.result        (result),
		.done          (done)
	);

endmodule

`default_nettype wire

// ===== verif/sorted_table_binary_search_tb.sv =====
`timescale 1ns / 1ps

module sorted_table_binary_search_tb;
	import stbs_pkg::*;

	localparam int unsigned DEPTH     = 16;
	localparam int unsigned CLK_HALF  = 6;
	localparam int unsigned CYCLE_CAP = 200000;
	// this exceeds the longest search from its accept edge to its result, so it covers it
	localparam int unsigned SETTLE    = 16;
	localparam int unsigned N_ITEMS   = 650;
	// the last stretch of the run goes at full rate
	localparam int unsigned CALM_TAIL = 80;

	localparam logic [2:0] ADDR_COUNT = {REG_ELEMENT_COUNT, 2'b00};
	localparam logic [2:0] ADDR_SPARE = {~REG_ELEMENT_COUNT, 2'b00};

	localparam int VMIN = 32'sh8000_0000;
	localparam int VMAX = 32'sh7fff_ffff;

	// mirror of the table and the count register, plus the answers still owed
	class search_scoreboard;
		logic signed [VALUE_W-1:0] entries [DEPTH];
		logic [COUNT_W-1:0]        count_reg;
		stbs_out_t                 awaited [$];
		int unsigned               mismatches;

		function new();
			count_reg  = '0;
			mismatches = 0;
		endfunction

		function void set_count(logic [COUNT_W-1:0] value);
			count_reg = value;
		endfunction

		// halving search over the first count entries, first matching midpoint wins
		function stbs_out_t lookup(logic signed [VALUE_W-1:0] key);
			int        lo;
			int        hi;
			int        mid;
			int        span;
			stbs_out_t ans;
			ans  = '0;
			span = count_reg;
			if (span > DEPTH)
				span = DEPTH;
			lo = 0;
			hi = span - 1;
			while (lo <= hi && !ans.found) begin
				mid = lo + (hi - lo) / 2;
				if (entries[mid] == key) begin
					ans.found    = 1'b1;
					ans.position = mid[INDEX_W-1:0];
				end else if (entries[mid] > key) begin
					hi = mid - 1;
				end else begin
					lo = mid + 1;
				end
			end
			return ans;
		endfunction

		function void note_beat(stbs_in_t beat);
			if (beat.opcode == OP_LOAD)
				entries[beat.entry_index] = beat.data_value;
			else
				awaited.push_back(lookup(beat.data_value));
		endfunction

		function void check_result(stbs_out_t got);
			stbs_out_t want;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: found=%0b position=%0d",
						got.found, got.position);
			end else begin
				want = awaited.pop_front();
				if (got.found !== want.found || got.position !== want.position) begin
					mismatches++;
					if (mismatches <= 10)
						$display("search result: expected found=%0b position=%0d, got found=%0b position=%0d",
							want.found, want.position, got.found, got.position);
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	stbs_in_t    item;
	logic        done;
	stbs_out_t   result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	search_scoreboard sb = new();
	int unsigned      cycles;
	int unsigned      sent;
	int               fill_vals [$];

	sorted_table_binary_search dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item    (item),
		.done    (done),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	// sample at the rising edge: results first, then the beat taken at this edge
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("Mismatches found");
			$finish;
		end else if (arst_n) begin
			if (done)
				sb.check_result(result);
			if (start && !busy)
				sb.note_beat(item);
		end
	end

	function automatic stbs_in_t make_load(int idx, int val);
		stbs_in_t b;
		b.opcode      = OP_LOAD;
		b.entry_index = idx[INDEX_W-1:0];
		b.data_value  = val;
		return b;
	endfunction

	function automatic stbs_in_t make_search(int key);
		stbs_in_t b;
		b.opcode      = OP_SEARCH;
		b.entry_index = 4'($urandom);
		b.data_value  = key;
		return b;
	endfunction

	// present one beat from the falling edge, optionally after a short idle burst,
	// and hold it until the block takes it; start stays high on return
	task automatic send_beat(input stbs_in_t beat, input bit may_idle);
		int gap;
		@(negedge clk);
		if (may_idle && $urandom_range(0, 4) == 0) begin
			gap   = $urandom_range(1, 3);
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start = 1'b1;
		item  = beat;
		do @(posedge clk); while (busy);
		sent++;
	endtask

	// drop start, let every owed answer arrive, then give the block time to go quiet
	task automatic settle_idle();
		@(negedge clk);
		start = 1'b0;
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = addr;
		pwdata  = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == ADDR_COUNT)
			sb.set_count(data[COUNT_W-1:0]);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// upper data bits carry noise, only the low count bits are meant to land
	task automatic write_count(input int value);
		apb_write(ADDR_COUNT, ($urandom & ~32'h1f) | value[COUNT_W-1:0]);
	endtask

	initial begin
		int i;
		int j;
		int v;
		int cnt;
		int n;
		int mode;
		int sel;
		int key;
		int searches;
		int roll;

		start   = 1'b0;
		item    = '0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		arst_n  = 1'b0;
		cycles  = 0;
		sent    = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// count is zero out of reset, so a search touches no entry and misses
		send_beat(make_search(VMIN), 1'b1);

		// fill the whole table once, sorted, with duplicates and both extremes;
		// from here on no entry is ever unwritten
		fill_vals = '{VMIN, VMIN, -1000, -1, 0, 0, 1, 5, 5, 5, 100, 1 << 20, 1 << 30,
			VMAX - 1, VMAX, VMAX};
		for (i = 0; i < DEPTH; i++)
			send_beat(make_load(i, fill_vals[i]), 1'b1);

		settle_idle();
		write_count(DEPTH);
		send_beat(make_search(VMIN), 1'b1);      // leftmost, duplicated
		send_beat(make_search(VMAX), 1'b1);      // rightmost, duplicated
		send_beat(make_search(5), 1'b1);         // run of three equal entries
		send_beat(make_search(3), 1'b1);         // gap in the middle
		send_beat(make_search(-2), 1'b1);        // gap on the left side

		// count above the depth saturates
		settle_idle();
		write_count(31);
		send_beat(make_search(VMAX), 1'b1);
		send_beat(make_search(100), 1'b1);

		// single entry, then a write to a register that does not exist
		settle_idle();
		write_count(1);
		send_beat(make_search(0), 1'b1);
		settle_idle();
		apb_write(ADDR_SPARE, 32'hffff_ffff);
		send_beat(make_search(VMIN), 1'b1);
		send_beat(make_search(VMAX), 1'b1);

		// random phases: new count, sorted refill of the searched span, then
		// searches mostly for keys that are present or just beside them
		while (sent < N_ITEMS) begin
			settle_idle();
			sel = $urandom_range(0, 19);
			if (sel == 0)
				cnt = 0;
			else if (sel == 1)
				cnt = $urandom_range(DEPTH + 1, 31);
			else if (sel <= 5)
				cnt = DEPTH;
			else
				cnt = $urandom_range(1, DEPTH);
			write_count(cnt);
			n    = (cnt > DEPTH) ? DEPTH : cnt;
			mode = $urandom_range(0, 2);

			fill_vals.delete();
			for (i = 0; i < n; i++) begin
				if (mode == 0)
					v = $urandom;
				else if (mode == 1)
					v = $urandom_range(0, 24) - 12;       // dense, many duplicates
				else begin
					sel = $urandom_range(0, 2);
					if (sel == 0)
						v = VMIN + $urandom_range(0, 3);
					else if (sel == 1)
						v = VMAX - $urandom_range(0, 3);
					else
						v = $urandom;
				end
				fill_vals.push_back(v);
			end
			for (i = 1; i < n; i++) begin
				v = fill_vals[i];
				j = i - 1;
				while (j >= 0 && fill_vals[j] > v) begin
					fill_vals[j + 1] = fill_vals[j];
					j--;
				end
				fill_vals[j + 1] = v;
			end

			// load order does not matter, only the final contents
			if ($urandom_range(0, 1))
				for (i = 0; i < n; i++)
					send_beat(make_load(i, fill_vals[i]), sent < N_ITEMS - CALM_TAIL);
			else
				for (i = n - 1; i >= 0; i--)
					send_beat(make_load(i, fill_vals[i]), sent < N_ITEMS - CALM_TAIL);

			searches = $urandom_range(6, 14);
			repeat (searches) begin
				roll = $urandom_range(0, 99);
				if (roll < 8) begin
					// stray load anywhere, may break the ordering
					send_beat(make_load($urandom_range(0, DEPTH - 1), $urandom),
						sent < N_ITEMS - CALM_TAIL);
				end else begin
					sel = $urandom_range(0, 9);
					if (n == 0 || sel == 0)
						key = $urandom;
					else if (sel == 1)
						key = $urandom_range(0, 1) ? VMIN : VMAX;
					else if (sel <= 3)
						key = fill_vals[$urandom_range(0, n - 1)] +
							($urandom_range(0, 1) ? 1 : -1);
					else
						key = fill_vals[$urandom_range(0, n - 1)];
					send_beat(make_search(key), sent < N_ITEMS - CALM_TAIL);
				end
			end
		end

		settle_idle();
		if (sb.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
